// ----- hw/rtl/gtg_pkg.sv -----
// shared types, constants and the arctangent table for the go-to-goal controller
// no dependencies
package gtg_pkg;

  localparam int unsigned CordicStages = 16;
  localparam int unsigned PosFracBits  = 16;
  localparam int unsigned AngShift     = 36 - PosFracBits;

  // cordic datapath width: 33 bit deltas grow by gain < 1.65 and a rotation
  localparam int unsigned CW = 36;
  localparam int unsigned ZW = 28;

  localparam logic signed [ZW-1:0] HalfPiQ24 = 28'sd26353589;
  localparam logic [23:0]          InvKQ24   = 24'd10188014;

  // config register indexes
  localparam logic [2:0] RegGoalX    = 3'd0;
  localparam logic [2:0] RegGoalY    = 3'd1;
  localparam logic [2:0] RegLinGain  = 3'd2;
  localparam logic [2:0] RegAngGain  = 3'd3;
  localparam logic [2:0] RegStopDist = 3'd4;

  // zero marks a null input vector, whose angle is forced to zero
  typedef struct packed {
    logic                 zero;
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic signed [ZW-1:0] z;
  } cordic_t;

  function automatic logic signed [ZW-1:0] atan_q24(input logic [4:0] i);
    logic signed [ZW-1:0] r;
    case (i)
      5'd0:  r = 28'sd13176795;
      5'd1:  r = 28'sd7778716;
      5'd2:  r = 28'sd4110060;
      5'd3:  r = 28'sd2086331;
      5'd4:  r = 28'sd1047214;
      5'd5:  r = 28'sd524117;
      5'd6:  r = 28'sd262123;
      5'd7:  r = 28'sd131069;
      default: r = (i > 5'd24) ? '0 : (28'sd1 <<< (5'd24 - i));
    endcase
    return r;
  endfunction

endpackage

// ----- hw/rtl/go_to_goal_p_controller.sv -----
// go-to-goal proportional controller top level: delta and quaternion prep,
// two cordic pipelines, gain multiply and saturation; depends on gtg_pkg, gtg_cordic
//
// Fully pipelined: one pose per clock while the output is not stalled; the stages are
// input register, prep, cordic fold, CordicStages rotations, scale, gain and
// output. The whole pipe advances when the output register is empty or
// taken, so a stall at the output holds every stage.
module go_to_goal_p_controller import gtg_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         cfg_we_i,
  input  logic [2:0]   cfg_idx_i,
  input  logic [31:0]  cfg_data_i,
  input  logic         s_axis_tvalid_i,
  output logic         s_axis_tready_o,
  // pos_x[31:0], pos_y[63:32], quat_x[79:64], quat_y, quat_z, quat_w[127:112]
  input  logic [127:0] s_axis_tdata_i,
  output logic         m_axis_tvalid_o,
  input  logic         m_axis_tready_i,
  // linear_cmd[31:0], angular_cmd[63:32], distance[95:64], arrived[96], zero pad
  output logic [103:0] m_axis_tdata_o
);

  localparam int unsigned Lat = CordicStages + 6;

  logic signed [31:0] goal_x_q, goal_y_q;
  logic [15:0] lin_gain_q, ang_gain_q;
  logic [31:0] stop_q;

  // config registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      goal_x_q   <= 32'sd196608;
      goal_y_q   <= 32'sd196608;
      lin_gain_q <= 16'd1229;
      ang_gain_q <= 16'd2458;
      stop_q     <= 32'd6554;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        RegGoalX:    goal_x_q   <= cfg_data_i;
        RegGoalY:    goal_y_q   <= cfg_data_i;
        RegLinGain:  lin_gain_q <= cfg_data_i[15:0];
        RegAngGain:  ang_gain_q <= cfg_data_i[15:0];
        RegStopDist: stop_q     <= cfg_data_i;
        default: ;
      endcase
    end
  end

  logic en;
  logic [Lat-1:0] vld_q;
  assign en = !m_axis_tvalid_o || m_axis_tready_i;
  assign s_axis_tready_o = en;

  // valid shift line
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[Lat-2:0], s_axis_tvalid_i};
    end
  end
  assign m_axis_tvalid_o = vld_q[Lat-1];

  // stage 1: input register
  logic signed [31:0] px_q, py_q;
  logic signed [15:0] qx_q, qy_q, qz_q, qw_q;
  always_ff @(posedge clk_i) begin
    if (en) begin
      px_q <= s_axis_tdata_i[31:0];
      py_q <= s_axis_tdata_i[63:32];
      qx_q <= s_axis_tdata_i[79:64];
      qy_q <= s_axis_tdata_i[95:80];
      qz_q <= s_axis_tdata_i[111:96];
      qw_q <= s_axis_tdata_i[127:112];
    end
  end

  // stage 2: deltas and quaternion products
  logic signed [CW-1:0] dx_q, dy_q, siny_q, cosy_q;
  logic signed [31:0] p_wz, p_xy, p_yy, p_zz;
  always_comb begin
    p_wz = qw_q * qz_q;
    p_xy = qx_q * qy_q;
    p_yy = qy_q * qy_q;
    p_zz = qz_q * qz_q;
  end
  always_ff @(posedge clk_i) begin
    if (en) begin
      dx_q   <= CW'(goal_x_q) - CW'(px_q);
      dy_q   <= CW'(goal_y_q) - CW'(py_q);
      siny_q <= (CW'(p_wz) + CW'(p_xy)) <<< 1;
      cosy_q <= (CW'(36'sd1) <<< 28) - ((CW'(p_yy) + CW'(p_zz)) <<< 1);
    end
  end

  logic signed [CW-1:0] mag, mag_unused;
  logic signed [ZW-1:0] bearing, yaw;

  gtg_cordic u_bear (
    .clk_i (clk_i), .en_i (en), .x_i (dx_q), .y_i (dy_q),
    .mag_o (mag), .ang_o (bearing)
  );
  gtg_cordic u_yaw (
    .clk_i (clk_i), .en_i (en), .x_i (cosy_q), .y_i (siny_q),
    .mag_o (mag_unused), .ang_o (yaw)
  );

  // stage: magnitude scaling and angle error
  logic [59:0] dist_full;
  logic [31:0] dist_q;
  logic signed [ZW:0] err_q;
  always_comb dist_full = mag[34:0] * InvKQ24 + 60'(1 << 23);
  always_ff @(posedge clk_i) begin
    if (en) begin
      dist_q <= (mag[CW-1] || |dist_full[59:56]) ? '1 : dist_full[55:24];
      err_q  <= (ZW+1)'(bearing) - (ZW+1)'(yaw);
    end
  end

  // stage: gain products and arrival compare
  logic [47:0] lin_p_q;
  logic signed [45:0] ang_p_q;
  logic [31:0] dist2_q;
  logic arr_q;
  always_ff @(posedge clk_i) begin
    if (en) begin
      lin_p_q <= lin_gain_q * dist_q;
      ang_p_q <= $signed({1'b0, ang_gain_q}) * err_q;
      dist2_q <= dist_q;
      arr_q   <= dist_q < stop_q;
    end
  end

  // output stage: rounding, saturation and arrival gating
  logic [47:0] lin_r;
  logic signed [45:0] ang_r;
  logic signed [45:0] ang_s;
  logic [31:0] lin_o, ang_o;
  always_comb begin
    lin_r = lin_p_q + 48'd2048;
    ang_r = ang_p_q + (46'sd1 <<< (AngShift - 1));
    ang_s = ang_r >>> AngShift;
    lin_o = (|lin_r[47:43]) ? 32'h7fff_ffff : {1'b0, lin_r[42:12]};
    if (ang_s > 46'sh7fff_ffff)         ang_o = 32'h7fff_ffff;
    else if (ang_s < -46'sh8000_0000)   ang_o = 32'h8000_0000;
    else                                ang_o = ang_s[31:0];
  end

  logic [103:0] out_q;
  always_ff @(posedge clk_i) begin
    if (en) begin
      out_q <= {7'd0, arr_q, dist2_q, arr_q ? 32'd0 : ang_o, arr_q ? 32'd0 : lin_o};
    end
  end
  assign m_axis_tdata_o = out_q;

endmodule

// ----- hw/rtl/gtg_cordic.sv -----
// pipelined vectoring cordic, one stage per register, with a pre-rotation stage
// depends on gtg_pkg
module gtg_cordic import gtg_pkg::*; (
  input  logic                 clk_i,
  input  logic                 en_i,
  input  logic signed [CW-1:0] x_i,
  input  logic signed [CW-1:0] y_i,
  output logic signed [CW-1:0] mag_o,
  output logic signed [ZW-1:0] ang_o
);

  cordic_t st_q [CordicStages+1];
  cordic_t pre_d;

  // quadrant fold for negative x
  always_comb begin
    pre_d.zero = (x_i == '0) && (y_i == '0);
    pre_d.x = x_i;
    pre_d.y = y_i;
    pre_d.z = '0;
    if (x_i < 0) begin
      if (y_i >= 0) begin
        pre_d.x = y_i;
        pre_d.y = -x_i;
        pre_d.z = HalfPiQ24;
      end else begin
        pre_d.x = -y_i;
        pre_d.y = x_i;
        pre_d.z = -HalfPiQ24;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      st_q[0] <= pre_d;
    end
  end

  // micro-rotation stages; arithmetic shifts floor as required
  for (genvar g = 0; g < CordicStages; g++) begin : g_stage
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        st_q[g+1].zero <= st_q[g].zero;
        if (st_q[g].y >= 0) begin
          st_q[g+1].x <= st_q[g].x + (st_q[g].y >>> g);
          st_q[g+1].y <= st_q[g].y - (st_q[g].x >>> g);
          st_q[g+1].z <= st_q[g].z + atan_q24(5'(g));
        end else begin
          st_q[g+1].x <= st_q[g].x - (st_q[g].y >>> g);
          st_q[g+1].y <= st_q[g].y + (st_q[g].x >>> g);
          st_q[g+1].z <= st_q[g].z - atan_q24(5'(g));
        end
      end
    end
  end

  // a null vector has angle zero
  assign mag_o = st_q[CordicStages].x;
  assign ang_o = st_q[CordicStages].zero ? '0 : st_q[CordicStages].z;

endmodule

// ----- tb/tb.sv -----
// testbench for the go-to-goal proportional controller: random poses and gains,
// bit-exact prediction of the commands; depends on gtg_pkg and go_to_goal_p_controller
`timescale 1ns / 1ps

class cmd_scoreboard;
  logic [103:0] pending[$];
  int errors;

  function void note(logic [103:0] w);
    pending.push_back(w);
  endfunction

  task check(logic [103:0] got);
    logic [103:0] want;
    if (pending.size() == 0) begin
      report_err("result word with nothing pending");
      return;
    end
    want = pending.pop_front();
    if (got[31:0] !== want[31:0])
      report_err($sformatf("linear_cmd got %h want %h", got[31:0], want[31:0]));
    if (got[63:32] !== want[63:32])
      report_err($sformatf("angular_cmd got %h want %h", got[63:32], want[63:32]));
    if (got[95:64] !== want[95:64])
      report_err($sformatf("distance got %h want %h", got[95:64], want[95:64]));
    if (got[96] !== want[96])
      report_err($sformatf("arrived got %b want %b", got[96], want[96]));
  endtask

  task report_err(string msg);
    errors++;
    $display("mismatch: %s", msg);
  endtask
endclass

module tb;
  import gtg_pkg::*;

  logic clk_i, rst_ni;
  logic cfg_we_i;
  logic [2:0] cfg_idx_i;
  logic [31:0] cfg_data_i;
  logic s_axis_tvalid_i, s_axis_tready_o;
  logic [127:0] s_axis_tdata_i;
  logic m_axis_tvalid_o, m_axis_tready_i;
  logic [103:0] m_axis_tdata_o;

  go_to_goal_p_controller DUT (.*);

  cmd_scoreboard sb;

  // shadow registers
  logic signed [31:0] goal_x, goal_y;
  logic [15:0] lin_gain, ang_gain;
  logic [31:0] stop_dist;
  bit in_done;

  initial begin
    clk_i = 0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #50_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

  function automatic longint atan_tab(int i);
    longint t[8] = '{13176795, 7778716, 4110060, 2086331, 1047214, 524117, 262123, 131069};
    if (i < 8) return t[i];
    if (i > 24) return 0;
    return longint'(1) << (24 - i);
  endfunction

  // vectoring cordic, returns angle in Q.24 and raw magnitude
  function automatic longint vec_angle(longint x, longint y, output longint mag);
    longint z, t, xn, yn;
    z = 0;
    if (x == 0 && y == 0) begin
      mag = 0;
      return 0;
    end
    if (x < 0) begin
      t = x;
      if (y >= 0) begin x = y; y = -t; z = 26353589; end
      else begin x = -y; y = t; z = -26353589; end
    end
    for (int i = 0; i < CordicStages; i++) begin
      if (y >= 0) begin
        xn = x + (y >>> i); yn = y - (x >>> i); z += atan_tab(i);
      end else begin
        xn = x - (y >>> i); yn = y + (x >>> i); z -= atan_tab(i);
      end
      x = xn; y = yn;
    end
    mag = x;
    return z;
  endfunction

  function automatic logic [103:0] predict_cmd(logic [127:0] d);
    longint dx, dy, qx, qy, qz, qw, mag, unused, bearing, yaw, siny, cosy, p, ang;
    longint unsigned dist_v, lin;
    logic [103:0] r;
    bit arr;
    dx = longint'(goal_x) - longint'($signed(d[31:0]));
    dy = longint'(goal_y) - longint'($signed(d[63:32]));
    qx = $signed(d[79:64]); qy = $signed(d[95:80]);
    qz = $signed(d[111:96]); qw = $signed(d[127:112]);
    bearing = vec_angle(dx, dy, mag);
    dist_v = (longint'(mag) * 10188014 + (longint'(1) << 23)) >>> 24;
    if (dist_v > 64'hFFFF_FFFF) dist_v = 64'hFFFF_FFFF;
    siny = 2 * (qw * qz + qx * qy);
    cosy = (longint'(1) << 28) - 2 * (qy * qy + qz * qz);
    yaw = vec_angle(cosy, siny, unused);
    arr = dist_v < stop_dist;
    r = '0;
    if (!arr) begin
      lin = (longint'(lin_gain) * dist_v + 2048) >> 12;
      if (lin > 64'h7FFF_FFFF) lin = 64'h7FFF_FFFF;
      p = longint'(ang_gain) * (bearing - yaw);
      ang = (p + (longint'(1) << (AngShift - 1))) >>> AngShift;
      if (ang > 64'sh7FFF_FFFF) ang = 64'sh7FFF_FFFF;
      if (ang < -64'sh8000_0000) ang = -64'sh8000_0000;
      r[31:0] = lin[31:0];
      r[63:32] = ang[31:0];
    end
    r[95:64] = dist_v[31:0];
    r[96] = arr;
    return r;
  endfunction

  task write_reg(logic [2:0] idx, logic [31:0] v);
    @(negedge clk_i);
    cfg_we_i <= 1; cfg_idx_i <= idx; cfg_data_i <= v;
    @(negedge clk_i);
    cfg_we_i <= 0;
    case (idx)
      RegGoalX: goal_x = v;
      RegGoalY: goal_y = v;
      RegLinGain: lin_gain = v[15:0];
      RegAngGain: ang_gain = v[15:0];
      RegStopDist: stop_dist = v;
      default: ;
    endcase
  endtask

  task set_all(logic [31:0] gx, logic [31:0] gy, logic [15:0] lg, logic [15:0] ag,
               logic [31:0] sd);
    write_reg(RegGoalX, gx);
    write_reg(RegGoalY, gy);
    write_reg(RegLinGain, {16'h0, lg});
    write_reg(RegAngGain, {16'h0, ag});
    write_reg(RegStopDist, sd);
  endtask

  // drop the input and wait until every result is back
  task wait_drained();
    s_axis_tvalid_i <= 0;
    while (sb.pending.size() != 0) @(negedge clk_i);
    repeat (CordicStages + 10) @(negedge clk_i);
  endtask

  // one pose word, held until accepted; valid stays up for a word that follows at once
  task send_pose(logic [127:0] d, bit gaps);
    int g;
    g = gaps ? $urandom_range(0, 11) : 0;
    if (g > 0) begin
      s_axis_tvalid_i <= 0;
      repeat (g) @(negedge clk_i);
    end
    s_axis_tvalid_i <= 1;
    s_axis_tdata_i <= d;
    @(posedge clk_i);
    while (!s_axis_tready_o) @(posedge clk_i);
    sb.note(predict_cmd(d));
    @(negedge clk_i);
  endtask

  function automatic logic [15:0] rand_q();
    case ($urandom_range(0, 3))
      0: return 16'(16384);
      1: return -16'sd16384;
      2: return 16'($urandom);
      default: return 16'($signed($urandom_range(0, 32768)) - 16384);
    endcase
  endfunction

  function automatic logic [31:0] rand_pos();
    case ($urandom_range(0, 4))
      0: return $urandom;
      1: return 32'h8000_0000;
      2: return 32'h7FFF_FFFF;
      default: return goal_x + 32'($signed($urandom_range(0, 1 << 20)) - (1 << 19));
    endcase
  endfunction

  function automatic logic [127:0] rand_pose();
    return {rand_q(), rand_q(), rand_q(), rand_q(),
            ($urandom_range(0, 3) == 0) ? $urandom : goal_y + 32'($urandom_range(0, 1 << 20)),
            rand_pos()};
  endfunction

  // output side: random stalls, sample at rising edge
  initial begin
    m_axis_tready_i = 0;
    forever begin
      @(negedge clk_i);
      if (in_done || $urandom_range(0, 3) != 0) m_axis_tready_i <= 1;
      else m_axis_tready_i <= 0;
    end
  end

  always @(posedge clk_i)
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) sb.check(m_axis_tdata_o);

  initial begin
    sb = new();
    in_done = 0;
    cfg_we_i = 0; cfg_idx_i = '0; cfg_data_i = '0;
    s_axis_tvalid_i = 0; s_axis_tdata_i = '0;
    goal_x = 196608; goal_y = 196608; lin_gain = 1229; ang_gain = 2458; stop_dist = 6554;
    rst_ni = 0;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1;

    // directed: reset settings, on goal, zero and extreme quaternions
    send_pose({64'h0, 32'd196608, 32'd196608}, 0);
    send_pose({64'h0, 32'd196700, 32'd196600}, 0);
    send_pose({16'sd16384, 16'h0, 16'h0, 16'h0, 64'h0}, 0);
    send_pose({16'h0, 16'sd16384, 16'hC000, 16'sd16384, 32'h8000_0000, 32'h8000_0000}, 0);
    send_pose({16'hC000, 16'hC000, 16'hC000, 16'hC000, 32'h7FFF_FFFF, 32'h7FFF_FFFF}, 0);
    send_pose({16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF}, 0);
    wait_drained();
    write_reg(3'd7, 32'hFFFF_FFFF); // out-of-range index ignored
    set_all(32'h7FFF_FFFF, 32'h8000_0000, 16'hFFFF, 16'hFFFF, 32'h0);
    send_pose({64'h0, 32'h7FFF_FFFF, 32'h8000_0000}, 0);
    send_pose({16'h0, 16'h0, 16'sd16384, 16'h0, 32'h8000_0000, 32'h7FFF_FFFF}, 0);
    send_pose({16'sd16384, 48'h0, 32'h0, 32'h0}, 0);
    wait_drained();
    set_all(32'h0, 32'h0, 16'h0, 16'h0, 32'hFFFF_FFFF);
    send_pose({64'h0, 32'h0, 32'h0}, 0);
    send_pose({rand_q(), rand_q(), rand_q(), rand_q(), 32'h1234_5678, 32'h8765_4321}, 0);
    wait_drained();

    // random phases with varied settings
    for (int ph = 0; ph < 8; ph++) begin
      set_all($urandom, $urandom, 16'($urandom), 16'($urandom),
              (ph % 2) ? $urandom_range(0, 1 << 18) : $urandom_range(0, 255));
      for (int n = 0; n < 240; n++) begin
        send_pose(rand_pose(), (n / 40) % 2 == 0);
        if (n == 100) wait_drained(); // sender holds off until drained
      end
      wait_drained();
    end
    in_done = 1;
    wait_drained();
    if (sb.errors == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end
endmodule
